/* rtl/jeps_pkg.sv */
// shared constants and types for the joint excitation profile sequencer
`timescale 1ns / 1ps
`default_nettype none

package jeps_pkg;

    typedef logic [2:0] reg_index_t;
    typedef logic [1:0] test_phase_t;
    typedef logic [2:0] mul_sel_t;

    // register indexes
    localparam reg_index_t REG_PRE_HOLD   = 3'd0;
    localparam reg_index_t REG_ACTIVE     = 3'd1;
    localparam reg_index_t REG_POST_HOLD  = 3'd2;
    localparam reg_index_t REG_REPEAT     = 3'd3;
    localparam reg_index_t REG_WAVE_MODE  = 3'd4;
    localparam reg_index_t REG_STEP       = 3'd5;
    localparam reg_index_t REG_SINE_PEAK  = 3'd6;
    localparam reg_index_t REG_PHASE_INC  = 3'd7;

    // register reset values
    localparam logic [31:0] PRE_HOLD_RESET  = 32'd2000;
    localparam logic [31:0] ACTIVE_RESET    = 32'd1000;
    localparam logic [31:0] POST_HOLD_RESET = 32'd2000;
    localparam logic [15:0] REPEAT_RESET    = 16'd3;
    localparam logic        WAVE_RESET      = 1'b0;
    localparam logic [31:0] STEP_RESET      = 32'd5243;
    localparam logic [31:0] PEAK_RESET      = 32'd4194;
    localparam logic [30:0] PHASE_INC_RESET = 31'd4294967;

    // test phase codes
    localparam test_phase_t PH_PRE_HOLD  = 2'd0;
    localparam test_phase_t PH_ACTIVE    = 2'd1;
    localparam test_phase_t PH_POST_HOLD = 2'd2;
    localparam test_phase_t PH_FINISHED  = 2'd3;

    // wave shapes
    localparam logic WAVE_STEP = 1'b0;
    localparam logic WAVE_SINE = 1'b1;

    // serial multiplier jobs
    localparam mul_sel_t MS_PHASE = 3'd0;
    localparam mul_sel_t MS_SIN   = 3'd1;
    localparam mul_sel_t MS_COS   = 3'd2;
    localparam mul_sel_t MS_OMEGA = 3'd3;
    localparam mul_sel_t MS_VEL   = 3'd4;

    // fixed point constants
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam int          SINE_W       = 31;
    localparam int          MUL_STEPS    = 32;

endpackage

`default_nettype wire

/* rtl/joint_excitation_profile_sequencer.sv */
// top level of the joint excitation profile sequencer
`timescale 1ns / 1ps
`default_nettype none

// Input beats (s_*) carry either a joint position sample (operation 0) or a
// control tick (operation 1). The first sample latches the primary and coupled
// baselines and restarts time; later samples are ignored and give no result.
// Each tick after latching gives one result beat (m_*) with the targets, the
// velocity, the phase of the current repeat and the repeat number.
// A sample is absorbed while the block is idle. A hold tick or a step tick
// passes through the eval, add and output states; a tick after the last
// repeat goes from eval straight to the output state. A sine tick forms
// five products through one bit-serial 32 x 32 shift-add multiplier, 32
// steps plus a result state each, with two sine table reads and the final
// add. The next beat is accepted once the result is in the output register,
// even while it still waits there. If the receiver stalls, the output
// register holds its beat and a further tick waits in its last cycle until
// the register is free. Reset restores the register defaults, drops the
// baseline and empties the output register. Registers are written through
// cfg_wr_en, cfg_index and cfg_data, one per cycle. The user writes them
// only while no tick is in progress; the block itself does not enforce it.
module joint_excitation_profile_sequencer
    import jeps_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire reg_index_t   cfg_index,
    input  wire [31:0]        cfg_data,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_operation,
    input  wire signed [31:0] s_primary_position,
    input  wire signed [31:0] s_coupled_position,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [31:0] m_primary_target,
    output logic signed [31:0] m_coupled_target,
    output logic signed [31:0] m_primary_velocity,
    output logic [1:0]        m_test_phase,
    output logic [15:0]       m_repeat_number
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PRD_W = 30 + IDX_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_LOOK = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // quarter-wave sine table, Q30
    logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] X  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) / 64'd6) >> 30;
        localparam logic [63:0] T2 = ((T1 * X2) / 64'd20) >> 30;
        localparam logic [63:0] T3 = ((T2 * X2) / 64'd42) >> 30;
        localparam logic [63:0] T4 = ((T3 * X2) / 64'd72) >> 30;
        localparam logic [63:0] T5 = ((T4 * X2) / 64'd110) >> 30;
        localparam logic [63:0] T6 = ((T5 * X2) / 64'd156) >> 30;
        localparam logic [63:0] T7 = ((T6 * X2) / 64'd210) >> 30;
        localparam logic [63:0] S  = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
        localparam logic [SINE_W-1:0] V = S[63] ? '0 :
            ((S > Q30_ONE) ? SINE_W'(Q30_ONE) : S[SINE_W-1:0]);
        assign sine_rom[k] = V;
    end

    // configuration registers
    logic [31:0] pre_hold_reg, active_reg, post_hold_reg;
    logic [15:0] repeat_total_reg;
    logic        wave_mode_reg;
    logic [31:0] step_offset_reg, sine_peak_reg;
    logic [30:0] phase_inc_reg;

    // sequencer state
    logic [2:0]  state_reg;
    logic        latched_reg;
    logic [31:0] base_p_reg, base_c_reg;
    logic [33:0] tick_reg;
    logic [15:0] rep_done_reg;
    logic [31:0] phase_reg;
    logic [32:0] act_end_reg;
    logic        look_cos_reg;
    logic        tsgn_reg;
    mul_sel_t    mul_sel_reg;
    logic [4:0]  mul_cnt_reg;
    logic [31:0] mul_a_reg;
    logic [63:0] mul_p_reg;
    logic signed [32:0] off_reg;
    logic [31:0] scl_mag_reg;
    logic        scl_neg_reg;
    logic [31:0] res_target_reg, res_vel_reg;
    logic [1:0]  res_phase_reg;
    logic [15:0] res_rep_reg;

    // output register
    logic        m_valid_reg;
    logic [31:0] m_pt_reg, m_ct_reg, m_pv_reg;
    logic [1:0]  m_ph_reg;
    logic [15:0] m_rn_reg;

    // eval decisions
    logic [32:0] act_end;
    logic        in_pre, in_act, finished;
    logic [31:0] at;

    always_comb begin
        act_end  = {1'b0, pre_hold_reg} + {1'b0, active_reg};
        in_pre   = tick_reg < {2'b00, pre_hold_reg};
        in_act   = tick_reg < {1'b0, act_end};
        at       = tick_reg[31:0] - pre_hold_reg;
        finished = (pre_hold_reg == '0 && active_reg == '0 && post_hold_reg == '0)
                   || (rep_done_reg >= repeat_total_reg);
    end

    // sine table lookup
    logic [31:0]       look_phase;
    logic [PRD_W-1:0]  frac_prod;
    logic [IDX_W-1:0]  idx, pos;
    logic [SINE_W-1:0] rom_val;

    always_comb begin
        look_phase = phase_reg + (look_cos_reg ? QUARTER_TURN : 32'd0);
        frac_prod  = {{IDX_W{1'b0}}, look_phase[29:0]} * PRD_W'(SINE_TABLE_DEPTH);
        idx        = frac_prod[PRD_W-1:30] + IDX_W'(frac_prod[29]);
        pos        = look_phase[30] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
        rom_val    = sine_rom[pos];
    end

    // bit-serial multiplier step and rounding
    logic [32:0] mul_hi;
    logic [33:0] rnd;
    logic        peak_neg;
    logic [31:0] peak_mag;

    always_comb begin
        mul_hi   = {1'b0, mul_p_reg[63:32]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : 33'd0);
        rnd      = mul_p_reg[63:30] + 34'(mul_p_reg[29]);
        peak_neg = sine_peak_reg[31];
        peak_mag = peak_neg ? (32'd0 - sine_peak_reg) : sine_peak_reg;
    end

    // saturations
    logic [31:0] vel_sat;
    logic signed [33:0] tgt_sum;
    logic [31:0] tgt_sat;

    always_comb begin
        if (!scl_neg_reg) begin
            vel_sat = (rnd > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
        end else begin
            vel_sat = (rnd > 34'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - rnd[31:0]);
        end
        tgt_sum = {{2{base_p_reg[31]}}, base_p_reg} + {off_reg[32], off_reg};
        if (tgt_sum[33:31] == 3'b000 || tgt_sum[33:31] == 3'b111) begin
            tgt_sat = tgt_sum[31:0];
        end else begin
            tgt_sat = tgt_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // cycle wrap
    logic [33:0] cycle_len, tick_inc;

    always_comb begin
        cycle_len = {1'b0, act_end_reg} + {2'b00, post_hold_reg};
        tick_inc  = tick_reg + 34'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_hold_reg     <= PRE_HOLD_RESET;
            active_reg       <= ACTIVE_RESET;
            post_hold_reg    <= POST_HOLD_RESET;
            repeat_total_reg <= REPEAT_RESET;
            wave_mode_reg    <= WAVE_RESET;
            step_offset_reg  <= STEP_RESET;
            sine_peak_reg    <= PEAK_RESET;
            phase_inc_reg    <= PHASE_INC_RESET;
            state_reg        <= ST_IDLE;
            latched_reg      <= 1'b0;
            base_p_reg       <= '0;
            base_c_reg       <= '0;
            tick_reg         <= '0;
            rep_done_reg     <= '0;
            phase_reg        <= '0;
            mul_cnt_reg      <= '0;
            mul_sel_reg      <= MS_PHASE;
            look_cos_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PRE_HOLD:  pre_hold_reg     <= cfg_data;
                    REG_ACTIVE:    active_reg       <= cfg_data;
                    REG_POST_HOLD: post_hold_reg    <= cfg_data;
                    REG_REPEAT:    repeat_total_reg <= cfg_data[15:0];
                    REG_WAVE_MODE: wave_mode_reg    <= cfg_data[0];
                    REG_STEP:      step_offset_reg  <= cfg_data;
                    REG_SINE_PEAK: sine_peak_reg    <= cfg_data;
                    REG_PHASE_INC: phase_inc_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!s_operation) begin
                            if (!latched_reg) begin
                                latched_reg  <= 1'b1;
                                base_p_reg   <= s_primary_position;
                                base_c_reg   <= s_coupled_position;
                                tick_reg     <= '0;
                                rep_done_reg <= '0;
                                phase_reg    <= '0;
                            end
                        end else if (latched_reg) begin
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_EVAL: begin
                    act_end_reg <= act_end;
                    res_vel_reg <= '0;
                    if (finished) begin
                        res_target_reg <= base_p_reg;
                        res_phase_reg  <= PH_FINISHED;
                        res_rep_reg    <= '0;
                        state_reg      <= ST_OUT;
                    end else begin
                        res_rep_reg <= rep_done_reg + 16'd1;
                        if (in_pre) begin
                            res_phase_reg <= PH_PRE_HOLD;
                            off_reg       <= '0;
                            state_reg     <= ST_ADD;
                        end else if (in_act) begin
                            res_phase_reg <= PH_ACTIVE;
                            if (wave_mode_reg == WAVE_SINE) begin
                                mul_a_reg    <= at;
                                mul_p_reg    <= {32'd0, 1'b0, phase_inc_reg};
                                mul_cnt_reg  <= '0;
                                mul_sel_reg  <= MS_PHASE;
                                look_cos_reg <= 1'b0;
                                state_reg    <= ST_MUL;
                            end else begin
                                off_reg   <= {step_offset_reg[31], step_offset_reg};
                                state_reg <= ST_ADD;
                            end
                        end else begin
                            res_phase_reg <= PH_POST_HOLD;
                            off_reg       <= '0;
                            state_reg     <= ST_ADD;
                        end
                    end
                end
                ST_MUL: begin
                    mul_p_reg   <= {mul_hi, mul_p_reg[31:1]};
                    mul_cnt_reg <= mul_cnt_reg + 5'd1;
                    if (mul_cnt_reg == 5'(MUL_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOOK: begin
                    tsgn_reg    <= look_phase[31];
                    mul_a_reg   <= peak_mag;
                    mul_p_reg   <= {32'd0, 1'b0, rom_val};
                    mul_cnt_reg <= '0;
                    mul_sel_reg <= look_cos_reg ? MS_COS : MS_SIN;
                    state_reg   <= ST_MUL;
                end
                ST_DONE: begin
                    mul_cnt_reg <= '0;
                    case (mul_sel_reg)
                        MS_PHASE: begin
                            phase_reg <= mul_p_reg[31:0];
                            state_reg <= ST_LOOK;
                        end
                        MS_SIN: begin
                            off_reg      <= (peak_neg ^ tsgn_reg)
                                            ? (33'd0 - {1'b0, rnd[31:0]})
                                            : {1'b0, rnd[31:0]};
                            look_cos_reg <= 1'b1;
                            state_reg    <= ST_LOOK;
                        end
                        MS_COS: begin
                            scl_mag_reg <= rnd[31:0];
                            scl_neg_reg <= peak_neg ^ tsgn_reg;
                            mul_a_reg   <= {1'b0, phase_inc_reg};
                            mul_p_reg   <= {32'd0, TWO_PI_Q28};
                            mul_sel_reg <= MS_OMEGA;
                            state_reg   <= ST_MUL;
                        end
                        MS_OMEGA: begin
                            mul_a_reg   <= scl_mag_reg;
                            mul_p_reg   <= {32'd0, rnd[31:0]};
                            mul_sel_reg <= MS_VEL;
                            state_reg   <= ST_MUL;
                        end
                        default: begin
                            res_vel_reg <= vel_sat;
                            state_reg   <= ST_ADD;
                        end
                    endcase
                end
                ST_ADD: begin
                    res_target_reg <= tgt_sat;
                    if (tick_inc >= cycle_len) begin
                        tick_reg     <= '0;
                        rep_done_reg <= rep_done_reg + 16'd1;
                    end else begin
                        tick_reg <= tick_inc;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_pt_reg    <= res_target_reg;
                        m_ct_reg    <= base_c_reg;
                        m_pv_reg    <= res_vel_reg;
                        m_ph_reg    <= res_phase_reg;
                        m_rn_reg    <= res_rep_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_primary_target   = m_pt_reg;
    assign m_coupled_target   = m_ct_reg;
    assign m_primary_velocity = m_pv_reg;
    assign m_test_phase       = m_ph_reg;
    assign m_repeat_number    = m_rn_reg;

endmodule

`default_nettype wire

/* rtl/jeps_checker.sv */
// port-level assertions for the joint excitation profile sequencer and their bind
`timescale 1ns / 1ps
`default_nettype none

module jeps_checker
    import jeps_pkg::*;
(
    input wire               aclk,
    input wire               aresetn,
    input wire               m_valid,
    input wire               m_ready,
    input wire signed [31:0] m_primary_target,
    input wire signed [31:0] m_coupled_target,
    input wire signed [31:0] m_primary_velocity,
    input wire [1:0]         m_test_phase,
    input wire [15:0]        m_repeat_number
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_primary_target)
            && $stable(m_coupled_target) && $stable(m_primary_velocity)
            && $stable(m_test_phase) && $stable(m_repeat_number))
        else $error("stalled result beat changed");

    // finished hold reports no repeat
    a_finished_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_test_phase == PH_FINISHED |-> m_repeat_number == 16'd0)
        else $error("finished hold with nonzero repeat number");

    // running repeats count from one
    a_running_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_test_phase != PH_FINISHED |-> m_repeat_number != 16'd0)
        else $error("running repeat numbered zero");

    // velocity only during the active phase
    a_hold_velocity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_test_phase != PH_ACTIVE |-> m_primary_velocity == 32'sd0)
        else $error("velocity outside active phase");

endmodule

bind joint_excitation_profile_sequencer jeps_checker u_jeps_checker (.*);

`default_nettype wire

/* tb/joint_excitation_profile_sequencer_test.sv */
// self-checking testbench for the joint excitation profile sequencer
`timescale 1ns / 1ps

module joint_excitation_profile_sequencer_test;
    import jeps_pkg::*;

    localparam int LUT_DEPTH = 256;
    localparam int QUIET_CYCLES = 200;
    localparam int RANDOM_BEATS = 1200;
    localparam logic [31:0] BASE_P = 32'h7FFF_FFFF;
    localparam logic [31:0] BASE_C = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] lead_tgt;
        logic [31:0] cpl_tgt;
        logic [31:0] primary_velocity;
        test_phase_t phase;
        logic [15:0] repeat_no;
    } command_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_index_t  idx;
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        command_t    want;
    } drill_row_t;

    localparam command_t NO_CMD    = '0;
    localparam command_t PRE1      = '{BASE_P, BASE_C, 32'd0, PH_PRE_HOLD, 16'd1};
    localparam command_t ACT1      = '{BASE_P, BASE_C, 32'd0, PH_ACTIVE, 16'd1};
    localparam command_t POST1     = '{BASE_P, BASE_C, 32'd0, PH_POST_HOLD, 16'd1};
    localparam command_t PRE2      = '{BASE_P, BASE_C, 32'd0, PH_PRE_HOLD, 16'd2};
    localparam command_t ACT2      = '{BASE_P, BASE_C, 32'd0, PH_ACTIVE, 16'd2};
    localparam command_t POST2     = '{BASE_P, BASE_C, 32'd0, PH_POST_HOLD, 16'd2};
    localparam command_t DONE_HOLD = '{BASE_P, BASE_C, 32'd0, PH_FINISHED, 16'd0};
    localparam command_t STEP_MIN4 = '{32'hFFFF_FFFF, BASE_C, 32'd0, PH_ACTIVE, 16'd4};
    localparam command_t PRE4      = '{BASE_P, BASE_C, 32'd0, PH_PRE_HOLD, 16'd4};

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    reg_index_t        cfg_index = REG_PRE_HOLD;
    logic [31:0]       cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = 1'b0;
    logic signed [31:0] s_primary_position = '0;
    logic signed [31:0] s_coupled_position = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [31:0] m_primary_target;
    logic signed [31:0] m_coupled_target;
    logic signed [31:0] m_primary_velocity;
    logic [1:0]        m_test_phase;
    logic [15:0]       m_repeat_number;

    // register copies
    logic [31:0] cfg_pre = PRE_HOLD_RESET;
    logic [31:0] cfg_active = ACTIVE_RESET;
    logic [31:0] cfg_post = POST_HOLD_RESET;
    logic [15:0] cfg_repeats = REPEAT_RESET;
    logic        cfg_wave = WAVE_RESET;
    logic [31:0] cfg_step = STEP_RESET;
    logic [31:0] cfg_peak = PEAK_RESET;
    logic [30:0] cfg_phase_inc = PHASE_INC_RESET;

    // sequencer state
    logic [31:0]     held_primary = '0;
    logic [31:0]     held_coupled = '0;
    logic            held_valid = 1'b0;
    longint unsigned cycle_tick = 0;
    logic [15:0]     repeats_done = '0;

    logic [31:0] sine_lut [0:LUT_DEPTH];
    command_t    pending_commands [$];

    int sender_idle_pct = 9;
    int receiver_idle_pct = 47;
    int errors = 0;
    int results_seen = 0;
    int sine_ticks = 0;
    int setups = 0;
    int phase_seen [4] = '{0, 0, 0, 0};

    drill_row_t drill [0:43] = '{
        '{ROW_WRITE, REG_PRE_HOLD, 32'd1, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_ACTIVE, 32'd2, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_POST_HOLD, 32'd1, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_REPEAT, 32'd2, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_WAVE_MODE, 32'(WAVE_STEP), 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_STEP, 32'h7FFF_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_CMD},
        '{ROW_SAMPLE, REG_PRE_HOLD, BASE_P, BASE_C, 1'b0, NO_CMD},
        '{ROW_SAMPLE, REG_PRE_HOLD, BASE_C, BASE_P, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, PRE1},
        '{ROW_TICK, REG_PRE_HOLD, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1, ACT1},
        '{ROW_TICK, REG_PRE_HOLD, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1, ACT1},
        '{ROW_TICK, REG_PRE_HOLD, 32'h1234_5678, 32'h8765_4321, 1'b1, POST1},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0001, 32'h8000_0000, 1'b1, PRE2},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, ACT2},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, ACT2},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, POST2},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, DONE_HOLD},
        '{ROW_SAMPLE, REG_PRE_HOLD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, DONE_HOLD},
        '{ROW_WRITE, REG_PRE_HOLD, 32'd0, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_ACTIVE, 32'd0, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_POST_HOLD, 32'd0, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_REPEAT, 32'h0000_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, DONE_HOLD},
        '{ROW_WRITE, REG_WAVE_MODE, 32'(WAVE_SINE), 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_ACTIVE, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_SINE_PEAK, 32'h8000_0000, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_PHASE_INC, 32'h7FFF_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_SINE_PEAK, 32'h7FFF_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_ACTIVE, 32'd1, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_WAVE_MODE, 32'(WAVE_STEP), 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_ACTIVE, 32'd3, 32'd0, 1'b0, NO_CMD},
        '{ROW_WRITE, REG_STEP, 32'h8000_0000, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, STEP_MIN4},
        '{ROW_WRITE, REG_PRE_HOLD, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, PRE4},
        '{ROW_WRITE, REG_PHASE_INC, 32'd0, 32'd0, 1'b0, NO_CMD},
        '{ROW_TICK, REG_PRE_HOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, PRE4}
    };

    joint_excitation_profile_sequencer dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic void build_sine_lut();
        longint unsigned x, x2, term;
        longint total;
        for (int k = 0; k <= LUT_DEPTH; k++) begin
            x = 64'(k) * HALF_PI_Q30 / 64'(LUT_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            total = signed'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2 / 64'(4 * n * n + 2 * n)) >> 30;
                if (n % 2 == 1) total = total - signed'(term);
                else total = total + signed'(term);
            end
            if (total < 0) total = 0;
            if (total > signed'(Q30_ONE)) total = signed'(Q30_ONE);
            sine_lut[k] = total[31:0];
        end
    endfunction

    function automatic longint round_shift(input longint v, input int sh);
        longint unsigned mag;
        mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
        return v;
    endfunction

    function automatic longint sine_q30(input logic [31:0] ph);
        longint unsigned idx;
        longint s;
        idx = (64'(ph[29:0]) * 64'(LUT_DEPTH) + (64'd1 << 29)) >> 30;
        if (ph[30]) idx = 64'(LUT_DEPTH) - idx;
        if (idx > 64'(LUT_DEPTH)) idx = 64'(LUT_DEPTH);
        s = longint'(sine_lut[idx]);
        return ph[31] ? -s : s;
    endfunction

    // returns 1 when the beat yields a command
    function automatic logic advance_sequencer(input logic op,
                                               input logic [31:0] pos_p, pos_c,
                                               output command_t cmd);
        longint unsigned cycle_len, act_end, at;
        longint target, vel, peak, omega, scaled;
        logic [31:0] ph;
        cmd = '0;
        if (!op) begin
            if (!held_valid) begin
                held_primary = pos_p;
                held_coupled = pos_c;
                held_valid = 1'b1;
                cycle_tick = 0;
                repeats_done = '0;
            end
            return 1'b0;
        end
        if (!held_valid) return 1'b0;
        cycle_len = 64'(cfg_pre) + 64'(cfg_active) + 64'(cfg_post);
        target = longint'(signed'(held_primary));
        vel = 0;
        cmd.cpl_tgt = held_coupled;
        if (cycle_len == 0 || repeats_done >= cfg_repeats) begin
            cmd.lead_tgt = held_primary;
            cmd.phase = PH_FINISHED;
            return 1'b1;
        end
        act_end = 64'(cfg_pre) + 64'(cfg_active);
        cmd.phase = PH_POST_HOLD;
        if (cycle_tick < 64'(cfg_pre)) begin
            cmd.phase = PH_PRE_HOLD;
        end else if (cycle_tick < act_end) begin
            cmd.phase = PH_ACTIVE;
            at = cycle_tick - 64'(cfg_pre);
            if (cfg_wave == WAVE_STEP) begin
                target = clamp32(target + longint'(signed'(cfg_step)));
            end else begin
                sine_ticks++;
                peak = longint'(signed'(cfg_peak));
                ph = 32'(at * 64'(cfg_phase_inc));
                target = clamp32(target + round_shift(peak * sine_q30(ph), 30));
                omega = signed'((64'(cfg_phase_inc) * 64'(TWO_PI_Q28) + (64'd1 << 29)) >> 30);
                scaled = round_shift(peak * sine_q30(ph + QUARTER_TURN), 30);
                vel = clamp32(round_shift(scaled * omega, 30));
            end
        end
        cmd.lead_tgt = target[31:0];
        cmd.primary_velocity = vel[31:0];
        cmd.repeat_no = repeats_done + 16'd1;
        cycle_tick++;
        if (cycle_tick >= cycle_len) begin
            cycle_tick = 0;
            repeats_done = repeats_done + 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what, input command_t want, got);
        errors++;
        if (errors <= 10) begin
            $display("%s: expected tgt=%h cpl=%h vel=%h phase=%0d rep=%0d",
                     what, want.lead_tgt, want.cpl_tgt,
                     want.primary_velocity, want.phase, want.repeat_no);
            $display("    got tgt=%h cpl=%h vel=%h phase=%0d rep=%0d",
                     got.lead_tgt, got.cpl_tgt,
                     got.primary_velocity, got.phase, got.repeat_no);
        end
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_PRE_HOLD:  cfg_pre = value;
            REG_ACTIVE:    cfg_active = value;
            REG_POST_HOLD: cfg_post = value;
            REG_REPEAT:    cfg_repeats = value[15:0];
            REG_WAVE_MODE: cfg_wave = value[0];
            REG_STEP:      cfg_step = value;
            REG_SINE_PEAK: cfg_peak = value;
            REG_PHASE_INC: cfg_phase_inc = value[30:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_beat(input logic op, input logic [31:0] pos_p, pos_c,
                             input logic typed, input command_t want);
        command_t cmd;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_primary_position <= pos_p;
        s_coupled_position <= pos_c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (advance_sequencer(op, pos_p, pos_c, cmd))
            pending_commands.push_back(typed ? want : cmd);
    endtask

    // hold off until every command is out and the block has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic new_setup();
        logic [31:0] value;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(1) == 0) continue;
            case (reg_index_t'(i))
                REG_PRE_HOLD, REG_ACTIVE, REG_POST_HOLD:
                    case ($urandom_range(9))
                        0: value = '0;
                        1: value = '1;
                        default: value = $urandom_range(5);
                    endcase
                REG_REPEAT:
                    case ($urandom_range(7))
                        0: value = '0;
                        1: value = 32'h0000_FFFF;
                        default: value = {16'd0, repeats_done + 16'($urandom_range(1, 4))};
                    endcase
                REG_WAVE_MODE:
                    value = $urandom_range(1) ? 32'(WAVE_SINE) : 32'(WAVE_STEP);
                REG_STEP, REG_SINE_PEAK:
                    case ($urandom_range(7))
                        0: value = 32'h7FFF_FFFF;
                        1: value = 32'h8000_0000;
                        2: value = 32'($urandom_range(8191)) - 32'd4096;
                        default: value = $urandom;
                    endcase
                REG_PHASE_INC:
                    case ($urandom_range(5))
                        0: value = 32'h7FFF_FFFF;
                        1: value = '0;
                        2: value = $urandom_range(1 << 24);
                        default: value = $urandom & 32'h7FFF_FFFF;
                    endcase
                default: value = '0;
            endcase
            write_reg(reg_index_t'(i), value);
        end
    endtask

    always @(posedge aclk) begin
        command_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_primary_target, m_coupled_target, m_primary_velocity,
                   m_test_phase, m_repeat_number};
            results_seen++;
            phase_seen[m_test_phase]++;
            if (pending_commands.size() == 0) begin
                note_failure("result beat with nothing pending", NO_CMD, got);
            end else begin
                want = pending_commands.pop_front();
                if (got !== want) note_failure("command mismatch", want, got);
            end
        end
    end

    initial begin
        int beats_sent;
        int burst;
        logic busy;
        logic op;
        beats_sent = 0;
        busy = 1'b0;
        build_sine_lut();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (drill[r]) begin
            if (drill[r].kind == ROW_WRITE) begin
                if (busy) settle();
                busy = 1'b0;
                write_reg(drill[r].idx, drill[r].a);
            end else begin
                send_beat(drill[r].kind == ROW_TICK, drill[r].a, drill[r].b,
                          drill[r].typed, drill[r].want);
                busy = 1'b1;
            end
        end

        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent < RANDOM_BEATS / 3) begin
                sender_idle_pct = 9;
                receiver_idle_pct = 47;
            end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
                sender_idle_pct = 47;
                receiver_idle_pct = 9;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            settle();
            new_setup();
            setups++;
            burst = $urandom_range(15, 50);
            repeat (burst) begin
                op = ($urandom_range(9) != 0);
                send_beat(op, $urandom, $urandom, 1'b0, NO_CMD);
                beats_sent++;
            end
        end
        settle();

        $display("covered %0d result beats over %0d register setups, %0d of them sine ticks",
                 results_seen, setups, sine_ticks);
        $display("by phase: pre-hold %0d, active %0d, post-hold %0d, finished %0d",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
        if (errors == 0) begin
            $display("joint_excitation_profile_sequencer_test: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("joint_excitation_profile_sequencer_test: errors");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timed out with %0d commands pending", pending_commands.size());
        $display("joint_excitation_profile_sequencer_test: errors");
        $finish;
    end

endmodule

/* joint_excitation_profile_sequencer.f */
rtl/jeps_pkg.sv
rtl/joint_excitation_profile_sequencer.sv
rtl/jeps_checker.sv
tb/joint_excitation_profile_sequencer_test.sv
